// ===== hw/rtl/lgpm_pkg.sv =====
// Shared types, constants and elaboration-time tables for the levels and gamma pixel map.
`default_nettype none

package lgpm_pkg;

	localparam int PIXEL_BITS      = 8;
	localparam int FRAC_BITS       = 16;
	localparam int GAMMA_FRAC_BITS = 12;
	localparam int GAMMA_BITS      = 16;
	localparam int EXP_Q           = 30;
	localparam int NUM_REGS        = 5;
	localparam int ADDR_W          = $clog2(4 * NUM_REGS);
	localparam int LUT_DEPTH       = 1 << PIXEL_BITS;
	localparam int DIV_W           = (PIXEL_BITS + FRAC_BITS > 2 * PIXEL_BITS + 1) ?
		PIXEL_BITS + FRAC_BITS : 2 * PIXEL_BITS + 1;
	localparam int LOG_W           = FRAC_BITS + $clog2(FRAC_BITS + 1);
	localparam int EXPO_W          = LOG_W + GAMMA_BITS - GAMMA_FRAC_BITS;

	localparam logic [GAMMA_BITS-1:0] ONE_G = GAMMA_BITS'(1 << GAMMA_FRAC_BITS);

	typedef enum logic [ADDR_W-3:0] {
		REG_BLACK_IN  = 3'd0,
		REG_WHITE_IN  = 3'd1,
		REG_INV_GAMMA = 3'd2,
		REG_BLACK_OUT = 3'd3,
		REG_WHITE_OUT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] black_in;
		logic [PIXEL_BITS-1:0] white_in;
		logic [GAMMA_BITS-1:0] inv_gamma;
		logic [PIXEL_BITS-1:0] black_out;
		logic [PIXEL_BITS-1:0] white_out;
	} cfg_t;

	typedef struct packed {
		logic                  we;
		logic [PIXEL_BITS-1:0] addr;
		logic [PIXEL_BITS-1:0] data;
	} lut_wr_t;

	typedef logic [EXP_Q-1:0] fact_arr_t [FRAC_BITS];

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bv;
		v   = v_in;
		res = '0;
		bv  = 64'd1 << 62;
		while (bv > v)
			bv = bv >> 2;
		while (bv != 64'd0) begin
			if (v >= res + bv) begin
				v   = v - (res + bv);
				res = (res >> 1) + bv;
			end else begin
				res = res >> 1;
			end
			bv = bv >> 2;
		end
		return res;
	endfunction

	// Factor i holds 2^(-2^-(i+1)) in Q.EXP_Q, each the square root of the one before.
	function automatic fact_arr_t exp_factors();
		fact_arr_t   f;
		logic [63:0] c;
		c = 64'd1 << (EXP_Q - 1);
		for (int i = 0; i < FRAC_BITS; i++) begin
			c    = isqrt64(c << EXP_Q);
			f[i] = c[EXP_Q-1:0];
		end
		return f;
	endfunction

	localparam fact_arr_t EXP_FACT = exp_factors();

endpackage

`default_nettype wire

// ===== hw/rtl/levels_gamma_pixel_map.sv =====
// Top level of the levels and gamma pixel map.
`default_nettype none

// Maps each gray pixel word through a levels curve with gamma: the input is normalized
// between black_in and white_in, raised to inv_gamma (Q4.12), and scaled between
// black_out and white_out, truncated. The curve lives in a 256-entry table memory that
// a sequential builder fills after reset and again after every configuration write;
// pixels are then a single table read. While the table is being built, in_stall stays
// high. Building an entry runs the divider for 24 steps, normalization for up to 9, and
// the logarithm and the power for 16 steps each.
// Once built, the block takes one word per clock unless out_stall holds it back. An
// accepted word is taken into the table read register at the accepting edge, and then
// into the output register once that register is empty or out_stall is low.
// With out_stall high the block still accepts one more word, held at the table output.
module levels_gamma_pixel_map (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [lgpm_pkg::PIXEL_BITS-1:0] pixel_in,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [lgpm_pkg::PIXEL_BITS-1:0] pixel_out,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [lgpm_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [31:0]                     pwdata,
	output logic      [31:0]                     prdata,
	output logic                                 pready
);
	import lgpm_pkg::*;

	cfg_t                  cfg;
	logic                  cfg_wr;
	logic                  busy;
	lut_wr_t               wr;
	logic                  in_accept;
	logic                  s1_move;
	logic                  valid_s1;
	logic [PIXEL_BITS-1:0] rd_data;
	logic                  out_valid_q;
	logic [PIXEL_BITS-1:0] pixel_out_q;

	lgpm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.cfg_wr  (cfg_wr)
	);

	// Every configuration write restarts the table build from the first entry.
	lgpm_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.restart (cfg_wr),
		.busy    (busy),
		.wr      (wr)
	);

	lgpm_lut u_lut (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (in_accept),
		.rd_addr (pixel_in),
		.rd_data (rd_data)
	);

	// The table read data holds until the next accepted word, so it serves as the
	// second slot of the output skid: a word may enter as long as stage one drains.
	assign s1_move   = ~out_valid_q | ~out_stall;
	assign in_stall  = busy | (valid_s1 & ~s1_move);
	assign in_accept = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= in_accept | (valid_s1 & ~s1_move);
			out_valid_q <= (valid_s1 & s1_move) | (out_valid_q & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 & s1_move)
			pixel_out_q <= rd_data;
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;

`ifndef SYNTHESIS
	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> valid_s1)
		else $error("accepted word did not reach the table output stage");

	a_cfg_rebuilds: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> busy)
		else $error("configuration write did not start a table build");

	a_no_read_during_build: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr.we && in_accept))
		else $error("word accepted while the table is being written");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/lgpm_regs.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none

module lgpm_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lgpm_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	output lgpm_pkg::cfg_t                   cfg,
	output logic                             cfg_wr
);
	import lgpm_pkg::*;

	reg_idx_t idx;
	cfg_t     cfg_q;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;
	assign cfg_wr = wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.black_in  <= '0;
			cfg_q.white_in  <= '1;
			cfg_q.inv_gamma <= ONE_G;
			cfg_q.black_out <= '0;
			cfg_q.white_out <= '1;
		end else if (wr_en) begin
			unique case (idx)
				REG_BLACK_IN:  cfg_q.black_in  <= pwdata[PIXEL_BITS-1:0];
				REG_WHITE_IN:  cfg_q.white_in  <= pwdata[PIXEL_BITS-1:0];
				REG_INV_GAMMA: cfg_q.inv_gamma <= pwdata[GAMMA_BITS-1:0];
				REG_BLACK_OUT: cfg_q.black_out <= pwdata[PIXEL_BITS-1:0];
				REG_WHITE_OUT: cfg_q.white_out <= pwdata[PIXEL_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_BLACK_IN:  prdata = 32'(cfg_q.black_in);
			REG_WHITE_IN:  prdata = 32'(cfg_q.white_in);
			REG_INV_GAMMA: prdata = 32'(cfg_q.inv_gamma);
			REG_BLACK_OUT: prdata = 32'(cfg_q.black_out);
			REG_WHITE_OUT: prdata = 32'(cfg_q.white_out);
			default:       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lgpm_engine.sv =====
// Table builder: computes the levels and gamma curve one entry at a time and writes it.
`default_nettype none

module lgpm_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire lgpm_pkg::cfg_t cfg,
	input  wire logic        restart,
	output logic             busy,
	output lgpm_pkg::lut_wr_t wr
);
	import lgpm_pkg::*;

	localparam int LP_W   = $clog2(DIV_W);
	localparam int LP_IDX = $clog2(FRAC_BITS);
	localparam int SH_W   = $clog2(FRAC_BITS + 1);
	localparam int KS_W   = $clog2(EXP_Q + 1);
	localparam int K_W    = EXPO_W - FRAC_BITS;
	localparam int NUM_W  = FRAC_BITS + 1;
	localparam int NW     = FRAC_BITS + PIXEL_BITS + 2;
	localparam int SQ_W   = 2 * FRAC_BITS + 2;
	localparam int GP_W   = LOG_W + GAMMA_BITS;
	localparam int EP_W   = 2 * EXP_Q + 1;
	localparam int Y_W    = PIXEL_BITS + 1;
	localparam logic [FRAC_BITS:0] ONE_T = {1'b1, {FRAC_BITS{1'b0}}};

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_CLASS = 10'b0000000010,
		ST_DIV   = 10'b0000000100,
		ST_NORM  = 10'b0000001000,
		ST_SQ    = 10'b0000010000,
		ST_GMUL  = 10'b0000100000,
		ST_EXP   = 10'b0001000000,
		ST_EFIN  = 10'b0010000000,
		ST_LMUL  = 10'b0100000000,
		ST_WRITE = 10'b1000000000
	} state_t;

	typedef enum logic [1:0] {
		DEN_ONE  = 2'd0,
		DEN_SPAN = 2'd1,
		DEN_FULL = 2'd2
	} den_t;

	state_t                  state_q, state_n;
	logic [PIXEL_BITS-1:0]   x_q, x_n;
	logic [LP_W-1:0]         lp_q, lp_n;
	logic [PIXEL_BITS-1:0]   span_q, span_n;
	logic [NUM_W-1:0]        num_q, num_n;
	den_t                    den_q, den_n;
	logic                    lvl_q, lvl_n;
	logic [DIV_W-1:0]        dvd_q, dvd_n;
	logic [PIXEL_BITS-1:0]   rem_q, rem_n;
	logic [DIV_W-1:0]        quo_q, quo_n;
	logic [FRAC_BITS:0]      m_q, m_n;
	logic [SH_W-1:0]         sh_q, sh_n;
	logic [FRAC_BITS-1:0]    frac_q, frac_n;
	logic [EXPO_W-1:0]       e_q, e_n;
	logic [EXP_Q:0]          acc_q, acc_n;
	logic [PIXEL_BITS-1:0]   q_q, q_n;

	logic                    rev, ig_zero, ig_unit;
	logic [PIXEL_BITS-1:0]   diff, d_c, span_c;
	logic [PIXEL_BITS:0]     r2, rsub;
	logic                    ge;
	logic [DIV_W-1:0]        qfin;
	logic [SQ_W-1:0]         sq;
	logic [FRAC_BITS+1:0]    sq_sh;
	logic [LOG_W-1:0]        neg;
	logic [GP_W-1:0]         gprod;
	logic [LP_IDX-1:0]       lp_idx, fidx;
	logic [FRAC_BITS-1:0]    ef;
	logic [EP_W-1:0]         eprod;
	logic [K_W-1:0]          k;
	logic                    kbig;
	logic [EXP_Q:0]          acc_sh, acc_sh2;
	logic [NUM_W-1:0]        num_e, num_c;
	logic [NUM_W+PIXEL_BITS-1:0] nprod;
	logic [FRAC_BITS:0]      bias;
	logic [NW-1:0]           nsum;
	logic [Y_W-1:0]          ysum;
	logic [PIXEL_BITS-1:0]   y;

	assign rev     = cfg.white_out < cfg.black_out;
	assign diff    = rev ? cfg.black_out - cfg.white_out : cfg.white_out - cfg.black_out;
	assign ig_zero = cfg.inv_gamma == '0;
	assign ig_unit = cfg.inv_gamma == ONE_G;

	// Normalized distance of the entry from the black point, over the input span.
	always_comb begin
		priority if (cfg.white_in <= cfg.black_in) begin
			d_c    = PIXEL_BITS'(x_q >= cfg.black_in);
			span_c = PIXEL_BITS'(1);
		end else if (x_q <= cfg.black_in) begin
			d_c    = '0;
			span_c = PIXEL_BITS'(1);
		end else if (x_q >= cfg.white_in) begin
			d_c    = PIXEL_BITS'(1);
			span_c = PIXEL_BITS'(1);
		end else begin
			d_c    = x_q - cfg.black_in;
			span_c = cfg.white_in - cfg.black_in;
		end
	end

	// One restoring division step per cycle.
	assign r2   = {rem_q, dvd_q[DIV_W-1]};
	assign rsub = r2 - {1'b0, span_q};
	assign ge   = r2 >= {1'b0, span_q};
	assign qfin = {quo_q[DIV_W-2:0], ge};

	// Logarithm by repeated squaring of the normalized mantissa.
	assign sq    = SQ_W'(m_q) * SQ_W'(m_q);
	assign sq_sh = sq[SQ_W-1:FRAC_BITS];
	assign neg   = (LOG_W'(sh_q) << FRAC_BITS) - LOG_W'(frac_q);
	assign gprod = GP_W'(neg) * GP_W'(cfg.inv_gamma);

	// Power of two as a product of root factors chosen by the fraction bits.
	assign lp_idx = lp_q[LP_IDX-1:0];
	assign fidx   = LP_IDX'(FRAC_BITS - 1) - lp_idx;
	assign ef     = e_q[FRAC_BITS-1:0];
	assign eprod  = EP_W'(acc_q) * EP_W'(EXP_FACT[lp_idx]);
	assign k      = e_q[EXPO_W-1:FRAC_BITS];
	assign kbig   = k > K_W'(EXP_Q);
	assign acc_sh  = acc_q >> k[KS_W-1:0];
	assign acc_sh2 = acc_sh >> (EXP_Q - FRAC_BITS);
	assign num_e   = acc_sh2[FRAC_BITS:0];
	assign num_c   = (num_e > ONE_T) ? ONE_T : num_e;

	// Output line: the bias turns the floor into a ceiling for a falling output range.
	always_comb begin
		unique case (den_q)
			DEN_SPAN: bias = NUM_W'(span_q - 1'b1);
			DEN_FULL: bias = ONE_T - 1'b1;
			default:  bias = '0;
		endcase
		if (!rev)
			bias = '0;
	end

	assign nprod = (NUM_W + PIXEL_BITS)'(num_q) * (NUM_W + PIXEL_BITS)'(diff);
	assign nsum  = NW'(nprod) + NW'(bias);
	assign ysum  = rev ? {1'b0, cfg.black_out} - {1'b0, q_q} : {1'b0, cfg.black_out} + {1'b0, q_q};
	assign y     = ysum[PIXEL_BITS] ? '1 : ysum[PIXEL_BITS-1:0];

	always_comb begin
		state_n = state_q;
		x_n     = x_q;
		lp_n    = lp_q;
		span_n  = span_q;
		num_n   = num_q;
		den_n   = den_q;
		lvl_n   = lvl_q;
		dvd_n   = dvd_q;
		rem_n   = rem_q;
		quo_n   = quo_q;
		m_n     = m_q;
		sh_n    = sh_q;
		frac_n  = frac_q;
		e_n     = e_q;
		acc_n   = acc_q;
		q_n     = q_q;
		unique case (state_q)
			ST_IDLE: ;
			ST_CLASS: begin
				span_n = span_c;
				if (d_c == '0) begin
					num_n   = NUM_W'(ig_zero);
					den_n   = DEN_ONE;
					state_n = ST_LMUL;
				end else if (d_c == span_c || ig_unit) begin
					num_n   = NUM_W'(d_c);
					den_n   = DEN_SPAN;
					state_n = ST_LMUL;
				end else begin
					dvd_n   = DIV_W'({d_c, {FRAC_BITS{1'b0}}});
					rem_n   = '0;
					lp_n    = '0;
					lvl_n   = 1'b0;
					state_n = ST_DIV;
				end
			end
			ST_DIV: begin
				dvd_n = dvd_q << 1;
				rem_n = ge ? rsub[PIXEL_BITS-1:0] : r2[PIXEL_BITS-1:0];
				quo_n = qfin;
				lp_n  = lp_q + 1'b1;
				if (lp_q == LP_W'(DIV_W - 1)) begin
					if (lvl_q) begin
						q_n     = qfin[PIXEL_BITS-1:0];
						state_n = ST_WRITE;
					end else if (qfin[FRAC_BITS-1:0] == '0) begin
						num_n   = ig_zero ? ONE_T : '0;
						den_n   = DEN_FULL;
						state_n = ST_LMUL;
					end else begin
						m_n     = {1'b0, qfin[FRAC_BITS-1:0]};
						sh_n    = '0;
						state_n = ST_NORM;
					end
				end
			end
			ST_NORM: begin
				if (m_q[FRAC_BITS]) begin
					lp_n    = '0;
					frac_n  = '0;
					state_n = ST_SQ;
				end else begin
					m_n  = m_q << 1;
					sh_n = sh_q + 1'b1;
				end
			end
			ST_SQ: begin
				m_n    = sq_sh[FRAC_BITS+1] ? sq_sh[FRAC_BITS+1:1] : sq_sh[FRAC_BITS:0];
				frac_n = {frac_q[FRAC_BITS-2:0], sq_sh[FRAC_BITS+1]};
				lp_n   = lp_q + 1'b1;
				if (lp_q == LP_W'(FRAC_BITS - 1))
					state_n = ST_GMUL;
			end
			ST_GMUL: begin
				e_n     = gprod[GP_W-1:GAMMA_FRAC_BITS];
				acc_n   = {1'b1, {EXP_Q{1'b0}}};
				lp_n    = '0;
				state_n = ST_EXP;
			end
			ST_EXP: begin
				if (ef[fidx])
					acc_n = eprod[2*EXP_Q:EXP_Q];
				lp_n = lp_q + 1'b1;
				if (lp_q == LP_W'(FRAC_BITS - 1))
					state_n = ST_EFIN;
			end
			ST_EFIN: begin
				num_n   = kbig ? '0 : num_c;
				den_n   = DEN_FULL;
				state_n = ST_LMUL;
			end
			ST_LMUL: begin
				if (den_q == DEN_SPAN) begin
					dvd_n   = DIV_W'(nsum);
					rem_n   = '0;
					lp_n    = '0;
					lvl_n   = 1'b1;
					state_n = ST_DIV;
				end else begin
					q_n     = (den_q == DEN_FULL) ? nsum[FRAC_BITS+PIXEL_BITS-1:FRAC_BITS] :
						nsum[PIXEL_BITS-1:0];
					state_n = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (x_q == '1) begin
					state_n = ST_IDLE;
				end else begin
					x_n     = x_q + 1'b1;
					state_n = ST_CLASS;
				end
			end
			default: state_n = ST_IDLE;
		endcase
		if (restart) begin
			state_n = ST_CLASS;
			x_n     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLASS;
			x_q     <= '0;
			lp_q    <= '0;
		end else begin
			state_q <= state_n;
			x_q     <= x_n;
			lp_q    <= lp_n;
		end
	end

	always_ff @(posedge clk) begin
		span_q <= span_n;
		num_q  <= num_n;
		den_q  <= den_n;
		lvl_q  <= lvl_n;
		dvd_q  <= dvd_n;
		rem_q  <= rem_n;
		quo_q  <= quo_n;
		m_q    <= m_n;
		sh_q   <= sh_n;
		frac_q <= frac_n;
		e_q    <= e_n;
		acc_q  <= acc_n;
		q_q    <= q_n;
	end

	assign busy = state_q != ST_IDLE;
	assign wr   = '{we: state_q == ST_WRITE, addr: x_q, data: y};

`ifndef SYNTHESIS
	a_sq_normalized: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQ) |-> m_q[FRAC_BITS])
		else $error("mantissa left the normalized range during squaring");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (x_q == '1))
		else $error("table build stopped before the last entry");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (span_q != '0))
		else $error("division by a zero input span");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/lgpm_lut.sv =====
// Curve table: one write port for the builder, one registered read port for pixels.
`default_nettype none

module lgpm_lut (
	input  wire logic                            clk,
	input  wire lgpm_pkg::lut_wr_t               wr,
	input  wire logic                            rd_en,
	input  wire logic [lgpm_pkg::PIXEL_BITS-1:0] rd_addr,
	output logic      [lgpm_pkg::PIXEL_BITS-1:0] rd_data
);
	import lgpm_pkg::*;

	logic [PIXEL_BITS-1:0] mem [LUT_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we)
			mem[wr.addr] <= wr.data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire
